[rtl/bang_pkg.sv]
// Package for the binary-angle arctangent block: widths, constants, codes
// and the status struct shared by the divider and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package bang_pkg;

	// Coordinate width; each coordinate is a two's complement value of this width
	localparam int COORD_WIDTH = 24;
	// Threshold table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int ENTRY_W     = 16;
	localparam int ANGLE_W     = 16;

	// Ratio |y|*256/|x|: dividend is |y| followed by eight zero bits
	localparam int FRAC_BITS  = 8;
	localparam int DIV_W      = COORD_WIDTH + FRAC_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_W);

	// Request operation codes
	localparam logic OP_ANGLE = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Angle constants
	localparam logic [ANGLE_W-1:0] ZERO_TURN    = 16'h0000;
	localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
	localparam logic [ANGLE_W-1:0] HALF_TURN    = 16'h8000;

	// Ratio above this saturates to a quarter turn
	localparam logic [DIV_W-1:0] RATIO_LIMIT = DIV_W'(32'hFB6A);

	// Binary search over the table
	localparam logic [IDX_W-1:0] SEARCH_START = IDX_W'(127);
	localparam logic [IDX_W-1:0] SEARCH_STEP0 = IDX_W'(64);
	localparam int               SEARCH_STEPS = 8;
	localparam int               STEP_CNT_W   = $clog2(SEARCH_STEPS);
	localparam int               ANGLE_LSB    = 6;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_st_t;

endpackage

[rtl/bang_req_if.sv]
// Request channel of the arctangent block: valid/ready plus the item payload.
// Depends on bang_pkg.
`timescale 1ns / 1ps

interface bang_req_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  operation;
	logic signed [bang_pkg::COORD_WIDTH-1:0] y_coord;
	logic signed [bang_pkg::COORD_WIDTH-1:0] x_coord;
	logic [bang_pkg::IDX_W-1:0]            entry_index;
	logic [bang_pkg::ENTRY_W-1:0]          entry_value;

	modport source (
		output valid, operation, y_coord, x_coord, entry_index, entry_value,
		input  ready
	);
	modport sink (
		input  valid, operation, y_coord, x_coord, entry_index, entry_value,
		output ready
	);
endinterface

[rtl/bang_rsp_if.sv]
// Response channel of the arctangent block: valid/ready plus the angle.
// Depends on bang_pkg.
`timescale 1ns / 1ps

interface bang_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bang_pkg::ANGLE_W-1:0]  angle;

	modport source (output valid, angle, input ready);
	modport sink (input valid, angle, output ready);
endinterface

[rtl/bang_tbl.sv]
// Threshold table: single synchronous RAM, one write and one read port,
// registered read data. Depends on bang_pkg.
`timescale 1ns / 1ps

module bang_tbl (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [bang_pkg::IDX_W-1:0]    wr_addr,
	input  logic [bang_pkg::ENTRY_W-1:0]  wr_data,
	input  logic                          rd_en,
	input  logic [bang_pkg::IDX_W-1:0]    rd_addr,
	output logic [bang_pkg::ENTRY_W-1:0]  rd_data
);

	logic [bang_pkg::ENTRY_W-1:0] mem [bang_pkg::TABLE_DEPTH];
	logic [bang_pkg::ENTRY_W-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/bang_div.sv]
// Restoring radix-2 divider: quotient = dividend / divisor, one bit a cycle.
// Depends on bang_pkg.
`timescale 1ns / 1ps

module bang_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [bang_pkg::DIV_W-1:0]        dividend,
	input  logic [bang_pkg::COORD_WIDTH-1:0]  divisor,
	output logic [bang_pkg::DIV_W-1:0]        quotient,
	output bang_pkg::div_st_t                 status
);

	localparam int CW = bang_pkg::COORD_WIDTH;
	localparam int DW = bang_pkg::DIV_W;

	logic [CW-1:0]                   rem_q;
	logic [DW-1:0]                   quo_q;
	logic [CW-1:0]                   dsr_q;
	logic [bang_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic [CW:0]   trial;
	logic          ge;
	logic [CW:0]   diff;

	// One quotient bit: shift in the next dividend bit and try to subtract
	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		ge    = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= bang_pkg::DIV_CNT_W'(DW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shifts out of quo_q as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

`ifndef ASSERT_OFF
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a running division");
	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(start))
		else $error("divider went busy without start");
`endif

endmodule

[rtl/binary_angle_atan2_top.sv]
// Top level of the binary-angle arctangent block: request decode, sequencer,
// table search, quadrant fix-up and response register.
// Depends on bang_pkg, bang_req_if, bang_rsp_if, bang_div, bang_tbl.
//
//  channel | dir | payload                                                   | handshake
//  req     | in  | operation, y_coord, x_coord, entry_index, entry_value     | valid/ready
//  rsp     | out | angle                                                     | valid/ready
//
// A table write request gives no response.
// An angle request runs the divider over COORD_WIDTH+8 quotient bits, then
// eight table search steps, each a read state and then a compare state.
// A zero coordinate skips the divider and the search; a saturated ratio
// skips the search.
// Reset clears control state only; the table holds garbage until written.
// A new request is taken while a finished angle still waits on rsp.
`timescale 1ns / 1ps

module binary_angle_atan2_top (
	input  logic             clk,
	input  logic             arst_n,
	bang_req_if.sink         req,
	bang_rsp_if.source       rsp
);

	localparam int CW = bang_pkg::COORD_WIDTH;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIV  = 5'b00010,
		S_RD   = 5'b00100,
		S_CMP  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t                            state_q;
	logic                              xneg_q;
	logic                              yneg_q;
	logic [bang_pkg::ANGLE_W-1:0]      a_q;
	logic [bang_pkg::IDX_W-1:0]        pos_q;
	logic [bang_pkg::STEP_CNT_W-1:0]   step_q;
	logic [bang_pkg::SEARCH_STEPS-2:0] res_q;
	logic                              rsp_valid_q;
	logic [bang_pkg::ANGLE_W-1:0]      rsp_angle_q;

	logic                              req_acc;
	logic                              is_write;
	logic                              start_div;
	logic [CW-1:0]                     y_raw;
	logic [CW-1:0]                     x_raw;
	logic [CW-1:0]                     y_mag;
	logic [CW-1:0]                     x_mag;
	logic                              y_zero;
	logic                              x_zero;
	logic [bang_pkg::DIV_W-1:0]        ratio;
	bang_pkg::div_st_t                 div_st;
	logic [bang_pkg::ENTRY_W-1:0]      thr;
	logic                              gt;
	logic [bang_pkg::IDX_W-1:0]        step_size;
	logic                              rsp_free;
	logic [bang_pkg::ANGLE_W-1:0]      a_xfix;
	logic [bang_pkg::ANGLE_W-1:0]      a_fix;

	// Request decode and coordinate magnitudes
	always_comb begin
		req_acc   = req.valid && req.ready;
		is_write  = req.operation == bang_pkg::OP_WRITE;
		y_raw     = req.y_coord;
		x_raw     = req.x_coord;
		y_mag     = y_raw[CW-1] ? (~y_raw + CW'(1)) : y_raw;
		x_mag     = x_raw[CW-1] ? (~x_raw + CW'(1)) : x_raw;
		y_zero    = y_raw == '0;
		x_zero    = x_raw == '0;
		start_div = req_acc && !is_write && !y_zero && !x_zero;
	end

	assign req.ready = state_q == S_IDLE;

	bang_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_div),
		.dividend ({y_mag, bang_pkg::FRAC_BITS'(0)}),
		.divisor  (x_mag),
		.quotient (ratio),
		.status   (div_st)
	);

	// Table writes land straight from the request; reads only during search,
	// which never overlaps a write since requests wait for S_IDLE
	bang_tbl u_tbl (
		.clk     (clk),
		.wr_en   (req_acc && is_write),
		.wr_addr (req.entry_index),
		.wr_data (req.entry_value),
		.rd_en   (state_q == S_RD),
		.rd_addr (pos_q),
		.rd_data (thr)
	);

	// Search step: compare, and halve the step each pass (last pass steps by 0)
	always_comb begin
		gt        = ratio > {{(bang_pkg::DIV_W - bang_pkg::ENTRY_W){1'b0}}, thr};
		step_size = bang_pkg::SEARCH_STEP0 >> step_q;
	end

	// Quadrant fix-up
	always_comb begin
		a_xfix   = xneg_q ? (bang_pkg::HALF_TURN - a_q) : a_q;
		a_fix    = yneg_q ? (bang_pkg::ZERO_TURN - a_xfix) : a_xfix;
		rsp_free = !rsp_valid_q || rsp.ready;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_acc && !is_write) begin
						state_q <= start_div ? S_DIV : S_DONE;
					end
				end
				S_DIV: begin
					if (div_st.done) begin
						state_q <= (ratio > bang_pkg::RATIO_LIMIT) ? S_DONE : S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					state_q <= (step_q == bang_pkg::STEP_CNT_W'(bang_pkg::SEARCH_STEPS - 1))
						? S_DONE : S_RD;
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Angle datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				xneg_q <= x_raw[CW-1];
				yneg_q <= y_raw[CW-1];
				a_q    <= y_zero ? bang_pkg::ZERO_TURN : bang_pkg::QUARTER_TURN;
			end
			S_DIV: begin
				pos_q  <= bang_pkg::SEARCH_START;
				step_q <= '0;
				a_q    <= bang_pkg::QUARTER_TURN;
			end
			S_CMP: begin
				pos_q  <= gt ? (pos_q + step_size) : (pos_q - step_size);
				step_q <= step_q + 1'b1;
				res_q  <= {res_q[bang_pkg::SEARCH_STEPS-3:0], gt};
				a_q    <= {2'b00, res_q, gt, bang_pkg::ANGLE_LSB'(0)};
			end
			default: begin
			end
		endcase
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && rsp_free) begin
			rsp_angle_q <= a_fix;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.angle = rsp_angle_q;

`ifndef ASSERT_OFF
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");
	a_write_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && is_write) |=> !$rose(rsp_valid_q))
		else $error("table write produced a response");
	a_angle_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		start_div |=> state_q == S_DIV && div_st.busy)
		else $error("angle request did not start the divider");
	a_rsp_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |=> rsp_valid_q)
		else $error("pending response dropped");
`endif

endmodule
